[rtl/fss_pkg.sv]
`timescale 1ns / 1ps
package fss_pkg;

  localparam int MAX_PATTERN   = 32;
  localparam int PAT_SLOTS     = 32;
  localparam int PAT_IDX_W     = 5;
  localparam int PLEN_W        = 6;
  localparam int COUNT_W       = 11;
  localparam int COUNT_LIMIT   = 2047;
  localparam int SCORE_W       = 14;
  localparam int SCORE_MAX     = 16383;
  localparam int RUN_W         = 5;
  localparam int RUN_MAX       = 31;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int PAT_WORDS     = 4;
  localparam int BYTES_PER_REG = 8;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = 2;
  localparam int QCNT_W        = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;

  // score terms
  localparam logic [SCORE_W-1:0] SCORE_EMPTY_PAT = 14'd100;
  localparam logic [SCORE_W-1:0] SCORE_EXACT     = 14'd1000;
  localparam logic [SCORE_W-1:0] SCORE_PREFIX    = 14'd600;
  localparam logic [COUNT_W-1:0] PREFIX_CAP      = 11'd100;
  localparam logic [COUNT_W-1:0] SURPLUS_CAP     = 11'd50;
  localparam logic [9:0]         PTS_MATCH       = 10'd20;
  localparam logic [9:0]         PTS_START       = 10'd60;
  localparam logic [9:0]         PTS_BOUNDARY    = 10'd45;
  localparam logic [9:0]         PTS_CAMEL       = 10'd40;
  localparam logic [3:0]         PTS_RUN_STEP    = 4'd15;

  typedef struct packed {
    logic [7:0] folded;
    logic       upper;
    logic       lower;
    logic       sep;
    logic       present;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [PLEN_W-1:0]  pos;
    logic [SCORE_W-1:0] score;
    logic               prefix_eq;
    logic [PLEN_W-1:0]  plen;
  } finish_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage

[rtl/fss_if.sv]
`timescale 1ns / 1ps
interface fss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] target_byte;
  logic       byte_present;
  logic       end_of_target;
  modport source (output valid, target_byte, byte_present, end_of_target, input ready);
  modport sink (input valid, target_byte, byte_present, end_of_target, output ready);
endinterface

interface fss_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] match_score;
  modport source (output valid, match_score, input ready);
  modport sink (input valid, match_score, output ready);
endinterface

interface fss_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/fss_front.sv]
`timescale 1ns / 1ps
module fss_front import fss_pkg::*; (
  fss_in_if.sink target,
  input  logic   queue_full,
  output logic   push,
  output item_t  item
);

  logic [7:0] b;

  assign b            = target.target_byte;
  assign target.ready = !queue_full;
  assign push         = target.valid && !queue_full;

  // classify the byte once so the back end only compares and adds
  always_comb begin
    item.folded  = fold(b);
    item.upper   = (b >= "A" && b <= "Z");
    item.lower   = (b >= "a" && b <= "z");
    item.sep     = b inside {8'h20, "-", "_", ".", "/"};
    item.present = target.byte_present;
    item.last    = target.end_of_target;
  end

endmodule

[rtl/fss_queue.sv]
`timescale 1ns / 1ps
module fss_queue import fss_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head,
  output logic  head_valid
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full       = (fill == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[rtl/fss_back.sv]
`timescale 1ns / 1ps
module fss_back import fss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  item_t             head,
  input  logic              head_valid,
  output logic              pop,
  input  logic [7:0]        pat_pre [PAT_SLOTS],
  input  logic [7:0]        pat_seq [PAT_SLOTS],
  input  logic [PLEN_W-1:0] plen,
  input  logic              snap_ready,
  output logic              snap_valid,
  output finish_t           snap
);

  logic [COUNT_W-1:0] count, count_next;
  logic [PLEN_W-1:0]  pos, pos_next;
  logic [SCORE_W-1:0] score, score_next;
  logic [RUN_W-1:0]   run, run_next, run_inc;
  logic               prev_matched, prev_matched_next;
  logic               prev_sep, prev_sep_next;
  logic               prev_lower, prev_lower_next;
  logic               prefix_eq, prefix_eq_next;
  logic               hit;
  logic [9:0]         add;
  logic [SCORE_W:0]   sum;

  assign pop        = head_valid && (!head.last || snap_ready);
  assign snap_valid = pop && head.last;

  assign run_inc = (run < RUN_W'(RUN_MAX)) ? run + 1'b1 : run;
  assign hit     = (pos < plen) && (pat_seq[pos[PAT_IDX_W-1:0]] == head.folded);

  always_comb begin
    count_next        = count;
    pos_next          = pos;
    run_next          = run;
    prev_matched_next = prev_matched;
    prev_sep_next     = prev_sep;
    prev_lower_next   = prev_lower;
    prefix_eq_next    = prefix_eq;
    add               = '0;
    if (head.present) begin
      if (count < COUNT_W'(plen) && pat_pre[count[PAT_IDX_W-1:0]] != head.folded) begin
        prefix_eq_next = 1'b0;
      end
      if (pos < plen) begin
        if (hit) begin
          add = PTS_MATCH;
          if (count == '0) begin
            add = add + PTS_START;
          end else if (prev_sep) begin
            add = add + PTS_BOUNDARY;
          end else if (prev_lower && head.upper) begin
            add = add + PTS_CAMEL;
          end
          if (prev_matched) begin
            run_next = run_inc;
            add      = add + (10'(run_inc) * 10'(PTS_RUN_STEP));
          end else begin
            run_next = '0;
          end
          prev_matched_next = 1'b1;
          pos_next          = pos + 1'b1;
        end else begin
          prev_matched_next = 1'b0;
          run_next          = '0;
        end
      end
      prev_sep_next   = head.sep;
      prev_lower_next = head.lower;
      if (count < COUNT_W'(COUNT_LIMIT)) count_next = count + 1'b1;
    end
    sum        = {1'b0, score} + (SCORE_W + 1)'(add);
    score_next = (sum > (SCORE_W + 1)'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX) : sum[SCORE_W-1:0];
  end

  always_comb begin
    snap.count     = count_next;
    snap.pos       = pos_next;
    snap.score     = score_next;
    snap.prefix_eq = prefix_eq_next;
    snap.plen      = plen;
  end

  always_ff @(posedge clk) begin
    if (rst || snap_valid) begin
      count        <= '0;
      pos          <= '0;
      score        <= '0;
      run          <= '0;
      prev_matched <= 1'b0;
      prev_sep     <= 1'b0;
      prev_lower   <= 1'b0;
      prefix_eq    <= 1'b1;
    end else if (pop) begin
      count        <= count_next;
      pos          <= pos_next;
      score        <= score_next;
      run          <= run_next;
      prev_matched <= prev_matched_next;
      prev_sep     <= prev_sep_next;
      prev_lower   <= prev_lower_next;
      prefix_eq    <= prefix_eq_next;
    end
  end

endmodule

[rtl/fss_finish.sv]
`timescale 1ns / 1ps
module fss_finish import fss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      snap_valid,
  input  finish_t   snap,
  output logic      snap_ready,
  fss_out_if.source score
);

  finish_t            held;
  logic               held_valid;
  logic               advance;
  logic [COUNT_W-1:0] plen_w;
  logic [COUNT_W-1:0] surplus;
  logic [SCORE_W-1:0] surplus_s;
  logic [SCORE_W-1:0] result;

  assign advance    = !score.valid || score.ready;
  assign snap_ready = !held_valid || advance;
  assign plen_w     = COUNT_W'(held.plen);

  always_comb begin
    surplus = (held.count > plen_w) ? held.count - plen_w : '0;
    if (surplus > SURPLUS_CAP) surplus = SURPLUS_CAP;
    surplus_s = SCORE_W'(surplus);
    if (held.plen == '0) begin
      result = SCORE_EMPTY_PAT;
    end else if (held.count == '0) begin
      result = '0;
    end else if (held.prefix_eq && held.count == plen_w) begin
      result = SCORE_EXACT;
    end else if (held.prefix_eq && held.count > plen_w) begin
      result = SCORE_PREFIX - SCORE_W'((held.count < PREFIX_CAP) ? held.count : PREFIX_CAP);
    end else if (COUNT_W'(held.pos) < plen_w) begin
      result = '0;
    end else if (held.score <= surplus_s) begin
      result = SCORE_W'(1);
    end else begin
      result = held.score - surplus_s;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) held <= snap;
    if (held_valid && advance) score.match_score <= result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      score.valid <= 1'b0;
    end else begin
      if (snap_ready) held_valid <= snap_valid;
      if (advance)    score.valid <= held_valid;
    end
  end

endmodule

[rtl/fuzzy_subsequence_scorer_unit.sv]
`timescale 1ns / 1ps
// The end-of-target beat is registered in the queue, the finish stage's held register and
// the output register in turn. The flow stalls when the queue is full or a score waits.
// Throughput: 1 beat per cycle outside stalls, set by the back end's per-byte compare-and-add.
// A 4-entry queue parts the front end from the back end; a finish stage and an output
// register let the next target stream in while a score waits to be taken.
// Reset (rst, synchronous): empties the queue and pipeline, clears the scoring state and
// zeroes every configuration register.
module fuzzy_subsequence_scorer_unit import fss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  fss_in_if.sink    target,
  fss_out_if.source score,
  fss_cfg_if.sink   cfg
);

  // Two copies of the folded pattern: one is walked by target position for the
  // prefix check, the other by pattern position for the subsequence match.
  logic [7:0]        pat_pre [PAT_SLOTS];
  logic [7:0]        pat_seq [PAT_SLOTS];
  logic [PLEN_W-1:0] plen;
  logic [PLEN_W-1:0] plen_in;
  logic              cfg_write;

  item_t   push_item;
  item_t   head;
  logic    push;
  logic    full;
  logic    pop;
  logic    head_valid;
  logic    snap_valid;
  logic    snap_ready;
  finish_t snap;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid;

  // clamp an oversized length to the pattern capacity once, at write time
  assign plen_in = (cfg.data[PLEN_W-1:0] > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN)
                                                                 : cfg.data[PLEN_W-1:0];

  // Fold case when the pattern is written, so the back end need not fold pattern bytes.
  // Indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
      for (int i = 0; i < PAT_SLOTS; i++) begin
        pat_pre[i] <= '0;
        pat_seq[i] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg.index)
        REG_PAT_0_7, REG_PAT_8_15, REG_PAT_16_23, REG_PAT_24_31: begin
          for (int j = 0; j < BYTES_PER_REG; j++) begin
            pat_pre[cfg.index[1:0]*BYTES_PER_REG + j] <= fold(cfg.data[j*8 +: 8]);
            pat_seq[cfg.index[1:0]*BYTES_PER_REG + j] <= fold(cfg.data[j*8 +: 8]);
          end
        end
        REG_PAT_LEN: begin
          plen <= plen_in;
        end
        default: begin
          plen <= plen;
        end
      endcase
    end
  end

  // front end: accept beats and classify each byte
  fss_front u_front (
    .target     (target),
    .queue_full (full),
    .push       (push),
    .item       (push_item)
  );

  // hold classified beats until the back end takes them
  fss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // back end: advance the match state one byte per cycle while a beat waits and a closing
  // beat can be taken; hand off the final state when a target closes and clear for the next one
  fss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .pat_pre    (pat_pre),
    .pat_seq    (pat_seq),
    .plen       (plen),
    .snap_ready (snap_ready),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  // reduce the closed target's state to one score and drive the result beat
  fss_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .score      (score)
  );

endmodule

[dv/fuzzy_subsequence_scorer_unit_test.sv]
`timescale 1ns / 1ps
// Drive target text one beat at a time into the scorer, predict every score
// with an independent model of the matching rules, and compare each score beat
// in order. Random gaps fall on both sides, except in one calm pattern phase.
// The score side also holds off once for a long stretch so that the input stalls.
module fuzzy_subsequence_scorer_unit_test;
  import fss_pkg::*;

  // One beat of the target channel as the sender sees it
  typedef struct packed {
    logic [7:0] tbyte;
    logic       present;
    logic       last;
  } text_beat_t;

  // Cycles to let pass after the last score before touching the registers:
  // the latency through the block plus the 4-entry queue and the finish stage, with margin.
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 250;
  localparam int PHASE_BEATS   = 175;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fss_in_if  text_ch ();
  fss_out_if score_ch ();
  fss_cfg_if cfg_ch ();

  fuzzy_subsequence_scorer_unit uut (
    .clk    (clk),
    .rst    (rst),
    .target (text_ch),
    .score  (score_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Stimulus and expectation stores
  text_beat_t  text_queue[$];
  logic [13:0] expected_scores[$];

  bit offering;   // a target beat is on the channel and not yet taken
  bit steady;     // no random gaps on either side
  bit hold_req;   // ask the score side for one long hold-off
  int stall_left;

  int mismatches;
  int scores_checked;
  int beats_taken;
  int bytes_taken;
  int pattern_loads;
  int planned_beats;

  // Shadow of the pattern registers
  logic [63:0] pat_word [PAT_WORDS];
  logic [5:0]  pat_len_reg;

  // Matching state of the target in progress
  int         tgt_count;
  int         hit_pos;
  int         acc_score;
  int         run_len;
  bit         prev_hit;
  bit         prefix_same;
  logic [7:0] prev_byte;

  // ---------------------------------------------------------------------------
  // Score prediction
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit is_separator(input logic [7:0] c);
    return c == " " || c == "-" || c == "_" || c == "." || c == "/";
  endfunction

  // Lengths above the pattern storage count as full storage
  function automatic int active_len();
    return (int'(pat_len_reg) > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len_reg);
  endfunction

  function automatic logic [7:0] pat_at(input int i);
    int k;
    k = i & 31;
    return pat_word[k >> 3][(k & 7) * 8 +: 8];
  endfunction

  task automatic clear_match();
    tgt_count   = 0;
    hit_pos     = 0;
    acc_score   = 0;
    run_len     = 0;
    prev_hit    = 1'b0;
    prefix_same = 1'b1;
    prev_byte   = 8'h00;
  endtask

  // Add points, saturating at the top of the score field
  task automatic bump(input int pts);
    acc_score += pts;
    if (acc_score > SCORE_MAX) acc_score = SCORE_MAX;
  endtask

  task automatic take_text_byte(input logic [7:0] b);
    int plen;
    logic [7:0] t;
    plen = active_len();
    t = to_lower(b);
    // Track whether the target still spells the pattern from its start
    if (tgt_count < plen && to_lower(pat_at(tgt_count)) != t) prefix_same = 1'b0;
    // Greedy subsequence step against the next unmatched pattern byte
    if (hit_pos < plen) begin
      if (to_lower(pat_at(hit_pos)) == t) begin
        bump(20);
        if (tgt_count == 0) begin
          bump(60);
        end else if (is_separator(prev_byte)) begin
          bump(45);
        end else if (prev_byte >= "a" && prev_byte <= "z" && b >= "A" && b <= "Z") begin
          bump(40);
        end
        if (prev_hit) begin
          if (run_len < RUN_MAX) run_len++;
          bump(run_len * 15);
        end else begin
          run_len = 0;
        end
        prev_hit = 1'b1;
        hit_pos++;
      end else begin
        prev_hit = 1'b0;
        run_len  = 0;
      end
    end
    prev_byte = b;
    if (tgt_count < COUNT_LIMIT) tgt_count++;
  endtask

  function automatic int closing_score();
    int plen;
    int surplus;
    plen = active_len();
    if (plen == 0) return 100;
    if (tgt_count == 0) return 0;
    if (prefix_same && tgt_count == plen) return 1000;
    if (prefix_same && tgt_count > plen) return 600 - ((tgt_count < 100) ? tgt_count : 100);
    if (hit_pos < plen) return 0;
    surplus = (tgt_count > plen) ? tgt_count - plen : 0;
    if (surplus > 50) surplus = 50;
    if (acc_score <= surplus) return 1;
    return acc_score - surplus;
  endfunction

  task automatic predict_beat(input text_beat_t bt);
    if (bt.present) begin
      take_text_byte(bt.tbyte);
      bytes_taken++;
    end
    if (bt.last) begin
      expected_scores.push_back(14'(closing_score()));
      clear_match();
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Target sender: offer the head of the queue at the falling edge, hold it
  // until taken, and skip cycles at random unless the phase is calm.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && !offering) begin
      if (text_queue.size() > 0 && (steady || $urandom_range(99) >= 18)) begin
        text_ch.valid         <= 1'b1;
        text_ch.target_byte   <= text_queue[0].tbyte;
        text_ch.byte_present  <= text_queue[0].present;
        text_ch.end_of_target <= text_queue[0].last;
        offering = 1'b1;
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  // Score receiver: random gaps, plus one long hold-off counted down here
  always @(negedge clk) begin
    if (hold_req) begin
      stall_left = HOLD_CYCLES;
      hold_req   = 1'b0;
    end
    if (rst) begin
      score_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      score_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      score_ch.ready <= steady || $urandom_range(99) >= 18;
    end
  end

  // Sample both channels at the rising edge: predict on every taken target
  // beat, check every taken score beat against the oldest expectation.
  always @(posedge clk) begin
    text_beat_t bt;
    logic [13:0] want;
    if (!rst) begin
      if (text_ch.valid && text_ch.ready) begin
        bt = '{tbyte: text_ch.target_byte, present: text_ch.byte_present,
               last: text_ch.end_of_target};
        void'(text_queue.pop_front());
        offering = 1'b0;
        beats_taken++;
        predict_beat(bt);
      end
      if (score_ch.valid && score_ch.ready) begin
        if (expected_scores.size() == 0) begin
          report_mismatch($sformatf("score %0d with no target closed", score_ch.match_score));
        end else begin
          want = expected_scores.pop_front();
          scores_checked++;
          if (score_ch.match_score !== want)
            report_mismatch($sformatf("match_score %0d, expected %0d",
                                      score_ch.match_score, want));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes and idle waits
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_PAT_0_7:   pat_word[0] = value;
      REG_PAT_8_15:  pat_word[1] = value;
      REG_PAT_16_23: pat_word[2] = value;
      REG_PAT_24_31: pat_word[3] = value;
      REG_PAT_LEN:   pat_len_reg = value[5:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_pattern(input logic [255:0] bytes, input logic [5:0] len);
    write_reg(REG_PAT_0_7, bytes[63:0]);
    write_reg(REG_PAT_8_15, bytes[127:64]);
    write_reg(REG_PAT_16_23, bytes[191:128]);
    write_reg(REG_PAT_24_31, bytes[255:192]);
    write_reg(REG_PAT_LEN, {58'd0, len});
    pattern_loads++;
  endtask

  // Wait until every beat is taken and every score has come back, then let the
  // pipeline drain in case a target is still open inside the block.
  task automatic settle();
    while (text_queue.size() != 0 || offering || expected_scores.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] separator_byte();
    logic [7:0] c;
    case ($urandom_range(4))
      0: c = " ";
      1: c = "-";
      2: c = "_";
      3: c = ".";
      default: c = "/";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] filler_byte();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'($urandom_range(122, 97));
    if (r < 55) return 8'($urandom_range(90, 65));
    if (r < 80) return separator_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pattern_char();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'($urandom_range(122, 97));
    if (r < 60) return 8'($urandom_range(90, 65));
    if (r < 75) return separator_byte();
    if (r < 85) return 8'($urandom_range(57, 48));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [255:0] random_pattern();
    logic [255:0] v;
    for (int i = 0; i < PAT_SLOTS; i++) v[i * 8 +: 8] = pattern_char();
    return v;
  endfunction

  function automatic logic [255:0] pack_text(input string s);
    logic [255:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < PAT_SLOTS; i++) v[i * 8 +: 8] = s[i];
    return v;
  endfunction

  // Flip the case of a letter half the time
  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(1) == 1)
      return c ^ 8'h20;
    return c;
  endfunction

  // Queue a target: a separate end beat without a byte when marker is set or
  // the body is empty, no end at all when open is set.
  task automatic push_text(input logic [7:0] body[$], input bit marker, input bit open,
                           input int idle_pct);
    text_beat_t bt;
    bit sep_end;
    sep_end = !open && (marker || body.size() == 0);
    foreach (body[i]) begin
      if (int'($urandom_range(99)) < idle_pct) begin
        bt = '{tbyte: 8'($urandom_range(255)), present: 1'b0, last: 1'b0};
        text_queue.push_back(bt);
        planned_beats++;
      end
      bt = '{tbyte: body[i], present: 1'b1,
             last: !open && !sep_end && i == body.size() - 1};
      text_queue.push_back(bt);
      planned_beats++;
    end
    if (sep_end) begin
      bt = '{tbyte: 8'($urandom_range(255)), present: 1'b0, last: 1'b1};
      text_queue.push_back(bt);
      planned_beats++;
    end
  endtask

  task automatic queue_string(input string s, input bit marker);
    logic [7:0] body[$];
    for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
    push_text(body, marker, 1'b0, 0);
  endtask

  // One random target built around the current pattern
  task automatic queue_target();
    logic [7:0] body[$];
    int plen;
    int pick;
    int cut;
    int extra;
    plen = active_len();
    pick = $urandom_range(99);
    if (plen == 0 && pick < 79) pick = 80;
    if (pick < 45) begin
      // subsequence with fillers between the pattern bytes
      for (int i = 0; i < plen; i++) begin
        repeat ($urandom_range(2)) body.push_back(filler_byte());
        body.push_back(flip_case(pat_at(i)));
      end
      extra = ($urandom_range(11) == 0) ? $urandom_range(70, 40) : $urandom_range(3);
      repeat (extra) body.push_back(filler_byte());
    end else if (pick < 69) begin
      // exact text, or exact text followed by a tail
      for (int i = 0; i < plen; i++) body.push_back(flip_case(pat_at(i)));
      if (pick >= 57) begin
        extra = ($urandom_range(7) == 0) ? $urandom_range(110, 95) : $urandom_range(8, 1);
        repeat (extra) body.push_back(filler_byte());
      end
    end else if (pick < 79) begin
      // only part of the pattern shows up
      cut = $urandom_range(plen - 1);
      for (int i = 0; i < cut; i++) begin
        repeat ($urandom_range(1)) body.push_back(filler_byte());
        body.push_back(flip_case(pat_at(i)));
      end
      repeat ($urandom_range(4)) body.push_back(filler_byte());
    end else if (pick < 94) begin
      repeat ($urandom_range(10, 1)) body.push_back(8'($urandom_range(255)));
    end
    push_text(body, $urandom_range(3) == 0, 1'b0, 5);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] body[$];
    int start_beats;

    text_ch.valid         = 1'b0;
    text_ch.target_byte   = 8'h00;
    text_ch.byte_present  = 1'b0;
    text_ch.end_of_target = 1'b0;
    score_ch.ready        = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_PAT_0_7;
    cfg_ch.data           = 64'd0;
    for (int i = 0; i < PAT_WORDS; i++) pat_word[i] = 64'd0;
    pat_len_reg = 6'd0;
    clear_match();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty pattern straight out of reset: any target scores 100, even an
    // empty one; an idle beat in between changes nothing.
    queue_string("ab", 1'b0);
    queue_string("", 1'b1);
    text_queue.push_back('{tbyte: 8'hFF, present: 1'b0, last: 1'b0});
    queue_string("Zq", 1'b0);
    settle();

    load_pattern(pack_text("aB"), 6'd2);
    queue_string("Ab", 1'b0);    // exact match, case folded
    queue_string("", 1'b1);      // empty target
    queue_string("abx", 1'b0);   // prefix match
    queue_string("x_ab", 1'b0);  // word boundary bonus, then a run
    queue_string("qaxB", 1'b0);  // camelCase bonus
    queue_string("ba", 1'b1);    // pattern not found, closed by a bare end beat
    settle();

    // Random phases, each under its own pattern setting
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: begin
          steady = 1'b1;
          load_pattern(random_pattern(), 6'($urandom_range(8, 1)));
        end
        1: begin
          steady = 1'b0;
          load_pattern(random_pattern(), 6'd32);
          // hold off scores while targets keep coming
          hold_req = 1'b1;
        end
        2: load_pattern({256{1'b1}}, 6'd32);
        3: load_pattern('0, 6'd63);
        4: load_pattern(random_pattern(), 6'd1);
        5: begin
          load_pattern(random_pattern(), 6'($urandom_range(6, 3)));
          // change the pattern words while a target is open
          body.delete();
          body.push_back(flip_case(pat_at(0)));
          body.push_back(flip_case(pat_at(1)));
          push_text(body, 1'b0, 1'b1, 0);
          settle();
          load_pattern(random_pattern(), 6'd6);
          body.delete();
          for (int i = 0; i < 6; i++) body.push_back(flip_case(pat_at(i)));
          push_text(body, 1'b0, 1'b0, 0);
          // lengthen the pattern past the bytes seen so far, then close
          body.delete();
          repeat (3) body.push_back(filler_byte());
          push_text(body, 1'b0, 1'b1, 0);
          settle();
          write_reg(REG_PAT_LEN, 64'd32);
          body.delete();
          push_text(body, 1'b1, 1'b0, 0);
          settle();
          load_pattern(random_pattern(), 6'd4);
          // long targets push the length counter into saturation
          body.delete();
          for (int i = 0; i < 4; i++) body.push_back(flip_case(pat_at(i)));
          repeat (COUNT_LIMIT + 20) body.push_back(filler_byte());
          push_text(body, 1'b0, 1'b0, 0);
          body.delete();
          for (int i = 0; i < 4; i++) body.push_back(" ");
          for (int i = 0; i < 4; i++) body.push_back(flip_case(pat_at(i)));
          repeat (COUNT_LIMIT) body.push_back(filler_byte());
          push_text(body, 1'b1, 1'b0, 0);
        end
        6: load_pattern(random_pattern(), 6'd0);
        default: load_pattern(random_pattern(), 6'($urandom_range(20, 9)));
      endcase
      start_beats = planned_beats;
      while (planned_beats - start_beats < PHASE_BEATS) queue_target();
      settle();
    end

    $display("Run covered %0d target beats carrying %0d text bytes under %0d pattern loads,",
             beats_taken, bytes_taken, pattern_loads);
    $display("with %0d scores checked across calm, gappy and long-stall stretches.",
             scores_checked);
    if (mismatches == 0 && expected_scores.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
